// ===== hdl/cau_pkg.sv =====
// Shared types and codes of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cau_cmd_e;

  // per-item control carried down the divider row
  typedef struct packed {
    logic valid;
    logic neg_re;
    logic neg_im;
    logic act_re;
    logic act_im;
    logic dz;
  } cau_ctrl_t;

endpackage

// ===== hdl/cau_in_if.sv =====
// Operand channel of the complex arithmetic unit: valid/ready plus one item.
// No dependencies.
interface cau_in_if #(parameter int unsigned DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic signed [DATA_WIDTH-1:0] a_real;
  logic signed [DATA_WIDTH-1:0] a_imag;
  logic signed [DATA_WIDTH-1:0] b_real;
  logic signed [DATA_WIDTH-1:0] b_imag;

  modport source (output valid, cmd, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, cmd, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ===== hdl/cau_out_if.sv =====
// Result channel of the complex arithmetic unit: valid/ready plus one item.
// No dependencies.
interface cau_out_if #(parameter int unsigned DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_real;
  logic signed [DATA_WIDTH-1:0] res_imag;
  logic                         overflow;
  logic                         div_by_zero;

  modport source (output valid, res_real, res_imag, overflow, div_by_zero, input ready);
  modport sink   (input valid, res_real, res_imag, overflow, div_by_zero, output ready);
endinterface

// ===== hdl/cau_front.sv =====
// Front stages: products, sums, magnitudes and divider set-up.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
  parameter int unsigned DW = 16,
  parameter int unsigned FB = 8,
  parameter int unsigned QB = DW + 1,
  parameter int unsigned MW = 2 * DW + 1,
  parameter int unsigned CW = MW + FB + QB
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [1:0]           cmd_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  input  logic signed [DW-1:0] c_i,
  input  logic signed [DW-1:0] d_i,
  output cau_ctrl_t            ctrl_o,
  output logic [MW-1:0]        den_o,
  output logic [CW-1:0]        rem_re_o,
  output logic [CW-1:0]        rem_im_o,
  output logic [QB-1:0]        q_re_o,
  output logic [QB-1:0]        q_im_o
);

  localparam int unsigned PW = 2 * DW;

  // stage 1: products and linear results
  logic                 v1_q;
  logic [1:0]           cmd1_q;
  logic signed [PW-1:0] ac_q, bd_q, bc_q, ad_q, cc_q, dd_q;
  logic signed [DW:0]   lin_re_d, lin_im_d, lin_re_q, lin_im_q;
  logic signed [PW-1:0] a_x, b_x, c_x, d_x;

  // sign-extended operands, so every product is formed at full width
  assign a_x = PW'(a_i);
  assign b_x = PW'(b_i);
  assign c_x = PW'(c_i);
  assign d_x = PW'(d_i);

  always_comb begin
    if (cmd_i == CMD_SUB) begin
      lin_re_d = {a_i[DW-1], a_i} - {c_i[DW-1], c_i};
      lin_im_d = {b_i[DW-1], b_i} - {d_i[DW-1], d_i};
    end else begin
      lin_re_d = {a_i[DW-1], a_i} + {c_i[DW-1], c_i};
      lin_im_d = {b_i[DW-1], b_i} + {d_i[DW-1], d_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd1_q   <= cmd_i;
      ac_q     <= a_x * c_x;
      bd_q     <= b_x * d_x;
      bc_q     <= b_x * c_x;
      ad_q     <= a_x * d_x;
      cc_q     <= c_x * c_x;
      dd_q     <= d_x * d_x;
      lin_re_q <= lin_re_d;
      lin_im_q <= lin_im_d;
    end
  end

  // stage 2: combine products, or pass the linear results on
  logic signed [MW-1:0] ac_x, bd_x, bc_x, ad_x;
  logic signed [MW-1:0] s_re_d, s_im_d, s_re_q, s_im_q;
  logic [MW-1:0]        den_d, den2_q;
  logic                 v2_q;
  logic [1:0]           cmd2_q;

  assign ac_x  = {ac_q[PW-1], ac_q};
  assign bd_x  = {bd_q[PW-1], bd_q};
  assign bc_x  = {bc_q[PW-1], bc_q};
  assign ad_x  = {ad_q[PW-1], ad_q};
  assign den_d = {1'b0, cc_q} + {1'b0, dd_q};

  always_comb begin
    case (cmd1_q)
      CMD_MUL: begin
        s_re_d = ac_x - bd_x;
        s_im_d = bc_x + ad_x;
      end
      CMD_DIV: begin
        s_re_d = ac_x + bd_x;
        s_im_d = bc_x - ad_x;
      end
      default: begin
        s_re_d = {{(MW-DW-1){lin_re_q[DW]}}, lin_re_q};
        s_im_d = {{(MW-DW-1){lin_im_q[DW]}}, lin_im_q};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd2_q <= cmd1_q;
      s_re_q <= s_re_d;
      s_im_q <= s_im_d;
      den2_q <= den_d;
    end
  end

  // stage 3: magnitudes, range pre-check, seed for the divider row
  logic          neg_re, neg_im;
  logic [MW-1:0] mag_re, mag_im, sh_re, sh_im;
  logic [CW-1:0] n_re, n_im, lim;
  logic          big_re, big_im, is_div, dz;
  logic [MW-1:0] cap_m;
  logic [QB-1:0] cap_q;
  cau_ctrl_t     ctrl_d;
  logic [QB-1:0] q_re_d, q_im_d;

  assign neg_re = s_re_q[MW-1];
  assign neg_im = s_im_q[MW-1];
  assign mag_re = neg_re ? MW'(-s_re_q) : MW'(s_re_q);
  assign mag_im = neg_im ? MW'(-s_im_q) : MW'(s_im_q);
  assign sh_re  = (cmd2_q == CMD_MUL) ? (mag_re >> FB) : mag_re;
  assign sh_im  = (cmd2_q == CMD_MUL) ? (mag_im >> FB) : mag_im;
  assign n_re   = {{(CW-MW){1'b0}}, mag_re} << FB;
  assign n_im   = {{(CW-MW){1'b0}}, mag_im} << FB;
  assign lim    = {{(CW-MW){1'b0}}, den2_q} << QB;
  assign big_re = n_re >= lim;
  assign big_im = n_im >= lim;
  assign is_div = cmd2_q == CMD_DIV;
  assign dz     = is_div && (den2_q == '0);
  // anything at or above 2^DW saturates the same way
  assign cap_m  = {{(MW-1){1'b0}}, 1'b1} << DW;
  assign cap_q  = {1'b1, {(QB-1){1'b0}}};

  always_comb begin
    ctrl_d.valid  = v2_q;
    ctrl_d.dz     = dz;
    ctrl_d.neg_re = neg_re && !dz;
    ctrl_d.neg_im = neg_im && !dz;
    ctrl_d.act_re = is_div && !dz && !big_re;
    ctrl_d.act_im = is_div && !dz && !big_im;
    if (is_div) begin
      q_re_d = (big_re && !dz) ? cap_q : '0;
      q_im_d = (big_im && !dz) ? cap_q : '0;
    end else begin
      q_re_d = (sh_re > cap_m) ? cap_q : sh_re[QB-1:0];
      q_im_d = (sh_im > cap_m) ? cap_q : sh_im[QB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (adv_i) begin
      ctrl_o <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_o    <= den2_q;
      rem_re_o <= n_re;
      rem_im_o <= n_im;
      q_re_o   <= q_re_d;
      q_im_o   <= q_im_d;
    end
  end

endmodule

// ===== hdl/cau_cell.sv =====
// One restoring-division cell: decides one quotient bit of both parts.
// Depends on cau_pkg.
module cau_cell import cau_pkg::*; #(
  parameter int unsigned MW    = 33,
  parameter int unsigned CW    = 58,
  parameter int unsigned QB    = 17,
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  cau_ctrl_t     ctrl_i,
  input  logic [MW-1:0] den_i,
  input  logic [CW-1:0] rem_re_i,
  input  logic [CW-1:0] rem_im_i,
  input  logic [QB-1:0] q_re_i,
  input  logic [QB-1:0] q_im_i,
  output cau_ctrl_t     ctrl_o,
  output logic [MW-1:0] den_o,
  output logic [CW-1:0] rem_re_o,
  output logic [CW-1:0] rem_im_o,
  output logic [QB-1:0] q_re_o,
  output logic [QB-1:0] q_im_o
);

  logic [CW-1:0] dsh;
  logic [QB-1:0] qbit;
  logic          ge_re, ge_im;

  assign dsh   = {{(CW-MW){1'b0}}, den_i} << SHIFT;
  assign qbit  = {{(QB-1){1'b0}}, 1'b1} << SHIFT;
  assign ge_re = ctrl_i.act_re && (rem_re_i >= dsh);
  assign ge_im = ctrl_i.act_im && (rem_im_i >= dsh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (adv_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_o    <= den_i;
      rem_re_o <= ge_re ? rem_re_i - dsh : rem_re_i;
      rem_im_o <= ge_im ? rem_im_i - dsh : rem_im_i;
      q_re_o   <= ge_re ? (q_re_i | qbit) : q_re_i;
      q_im_o   <= ge_im ? (q_im_i | qbit) : q_im_i;
    end
  end

endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// Channel  Dir  Modport           Payload
// in_i     in   cau_in_if.sink    cmd, a_real, a_imag, b_real, b_imag
// out_o    out  cau_out_if.source res_real, res_imag, overflow, div_by_zero
//
// One item per cycle unless the output stalls. Stages: three front stages, a
// row of DATA_WIDTH+1 division cells (one quotient bit each), output register.
// Every item runs the full row, whatever its command.
// Reset clears the valid bits and the per-item control words only; data registers are left as they are.
// A stalled output freezes the whole pipeline and holds in_i.ready low.
// Top level of the complex arithmetic unit; depends on cau_pkg, cau_in_if,
// cau_out_if, cau_front and cau_cell.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned QB = DW + 1;
  localparam int unsigned MW = 2 * DW + 1;
  localparam int unsigned CW = MW + FRAC_BITS + QB;

  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  cau_ctrl_t     ctrl   [QB+1];
  logic [MW-1:0] den    [QB+1];
  logic [CW-1:0] rem_re [QB+1];
  logic [CW-1:0] rem_im [QB+1];
  logic [QB-1:0] q_re   [QB+1];
  logic [QB-1:0] q_im   [QB+1];

  cau_front #(.DW(DW), .FB(FRAC_BITS), .QB(QB), .MW(MW), .CW(CW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_i.valid),
    .cmd_i    (in_i.cmd),
    .a_i      (in_i.a_real),
    .b_i      (in_i.a_imag),
    .c_i      (in_i.b_real),
    .d_i      (in_i.b_imag),
    .ctrl_o   (ctrl[0]),
    .den_o    (den[0]),
    .rem_re_o (rem_re[0]),
    .rem_im_o (rem_im[0]),
    .q_re_o   (q_re[0]),
    .q_im_o   (q_im[0])
  );

  // most significant quotient bit first
  for (genvar k = 0; k < QB; k++) begin : g_cell
    cau_cell #(.MW(MW), .CW(CW), .QB(QB), .SHIFT(QB - 1 - k)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .ctrl_i   (ctrl[k]),
      .den_i    (den[k]),
      .rem_re_i (rem_re[k]),
      .rem_im_i (rem_im[k]),
      .q_re_i   (q_re[k]),
      .q_im_i   (q_im[k]),
      .ctrl_o   (ctrl[k+1]),
      .den_o    (den[k+1]),
      .rem_re_o (rem_re[k+1]),
      .rem_im_o (rem_im[k+1]),
      .q_re_o   (q_re[k+1]),
      .q_im_o   (q_im[k+1])
    );
  end

  // clamp a sign and magnitude to DW bits; top bit of the result is overflow
  function automatic logic [DW:0] sat(input logic neg, input logic [QB-1:0] mag);
    logic [QB-1:0] lim;
    logic          ovf;
    logic [DW-1:0] r;
    lim = {{(QB-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
    if (!neg) begin
      ovf = mag > (lim - {{(QB-1){1'b0}}, 1'b1});
      r   = ovf ? {1'b0, {(DW-1){1'b1}}} : mag[DW-1:0];
    end else begin
      ovf = mag > lim;
      r   = ovf ? {1'b1, {(DW-1){1'b0}}} : DW'(-mag[DW-1:0]);
    end
    return {ovf, r};
  endfunction

  logic [DW:0] sat_re, sat_im;
  assign sat_re = sat(ctrl[QB].neg_re, q_re[QB]);
  assign sat_im = sat(ctrl[QB].neg_im, q_im[QB]);

  logic [DW-1:0] res_re_q, res_im_q;
  logic          ovf_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctrl[QB].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_q <= sat_re[DW-1:0];
      res_im_q <= sat_im[DW-1:0];
      ovf_q    <= sat_re[DW] || sat_im[DW];
      dz_q     <= ctrl[QB].dz;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.res_real    = res_re_q;
  assign out_o.res_imag    = res_im_q;
  assign out_o.overflow    = ovf_q;
  assign out_o.div_by_zero = dz_q;

  localparam logic [DW-1:0] PosMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NegMin = {1'b1, {(DW-1){1'b0}}};

  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.div_by_zero) |->
      (out_o.res_real == '0 && out_o.res_imag == '0 && !out_o.overflow))
    else $error("divide by zero item not cleared");

  a_ovf_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |->
      (out_o.res_real == PosMax || out_o.res_real == NegMin ||
       out_o.res_imag == PosMax || out_o.res_imag == NegMin))
    else $error("overflow flagged without a clamped part");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the pipeline is frozen");

endmodule
